[rtl/palmdoc_lz77_decompressor_top_defines.svh]
// ----------------------------------------------------------------------------
// palmdoc_lz77_decompressor_top_defines
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef PALMDOC_LZ77_DECOMPRESSOR_TOP_DEFINES_SVH
`define PALMDOC_LZ77_DECOMPRESSOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PDLZ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdlz: %m failed");

// next-cycle implication, sampled on clk, off during reset
`define PDLZ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdlz: %m failed");

`endif

[rtl/pdlz_pkg.sv]
// ----------------------------------------------------------------------------
// pdlz_pkg
// types and constants shared by the palmdoc lz77 decompressor modules
// ----------------------------------------------------------------------------
package pdlz_pkg;

  localparam logic [15:0] LIMIT_RESET = 16'd16416;
  localparam logic [7:0]  RUN_MAX     = 8'h08;
  localparam logic [7:0]  LIT_MAX     = 8'h7F;
  localparam logic [7:0]  PAIR_MAX    = 8'hBF;
  localparam logic [7:0]  XOR_MASK    = 8'h80;
  localparam logic [7:0]  SPACE_CHAR  = 8'h20;
  localparam logic [3:0]  LEN_BASE    = 4'd3;

  // record status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DIST = 2'd1;
  localparam logic [1:0] ST_CUT      = 2'd2;
  localparam logic [1:0] ST_LIMIT    = 2'd3;

  typedef enum logic [1:0] {
    KIND_LIT,
    KIND_SPACE,
    KIND_RUN,
    KIND_COPY
  } pdlz_kind_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic fetch;
    logic emit;
    logic mark;
  } pdlz_cmd_t;

  typedef struct packed {
    logic dec_zero;
    logic dec_copy;
    logic job_copy;
    logic emit_last;
    logic rec_last;
    logic out_free;
  } pdlz_stat_t;

endpackage

[rtl/pdlz_ctrl.sv]
// ----------------------------------------------------------------------------
// pdlz_ctrl
// sequencer: accept, decode, then emit the item's bytes one at a time
// ----------------------------------------------------------------------------
module pdlz_ctrl import pdlz_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  pdlz_stat_t stat,
  output pdlz_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_MARK   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (!stat.dec_zero) begin
          state_nxt = stat.dec_copy ? S_FETCH : S_EMIT;
        end else if (stat.rec_last) begin
          state_nxt = S_MARK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_nxt = S_IDLE;
          end else if (stat.job_copy) begin
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_MARK: begin
        if (stat.out_free) begin
          cmd.mark  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/pdlz_dpath.sv]
// ----------------------------------------------------------------------------
// pdlz_dpath
// decode state, run buffer, history memory and the output register
// ----------------------------------------------------------------------------
module pdlz_dpath import pdlz_pkg::*; #(
  parameter int HISTORY_DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic [7:0]  in_byte,
  input  logic        in_record_end,
  input  pdlz_cmd_t   cmd,
  output pdlz_stat_t  stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_run_last,
  output logic        out_record_done,
  output logic [1:0]  out_status,
  output logic [15:0] out_decoded_length
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0]   DEPTH_C  = (AW+1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

  logic [7:0]    hist_mem [HISTORY_DEPTH];
  logic [7:0]    run_buf  [8];

  logic [15:0]   out_limit_r;
  logic [15:0]   out_count_r;
  logic [AW-1:0] wp_r;
  logic          pend_r;
  logic [7:0]    high_r;
  logic [3:0]    exp_r;
  logic [3:0]    filled_r;
  logic [1:0]    halt_r;
  pdlz_kind_t    kind_r;
  logic [3:0]    cnt_r;
  logic [3:0]    k_r;
  logic [7:0]    c_r;
  logic          last_r;
  logic [10:0]   dist_r;
  logic [7:0]    rdata_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_bv_r;
  logic          out_rl_r;
  logic          out_rd_r;
  logic [1:0]    out_st_r;
  logic [15:0]   out_len_r;

  // decode results
  logic          pend_nxt;
  logic [7:0]    high_nxt;
  logic [3:0]    exp_nxt;
  logic [3:0]    filled_nxt;
  logic [1:0]    halt_nxt;
  pdlz_kind_t    kind_nxt;
  logic [3:0]    cnt_nxt;
  logic          run_wr;

  logic [10:0]   copy_dist;
  logic [3:0]    len;
  logic [16:0]   oc17;
  logic [16:0]   lim17;
  logic [16:0]   room17;
  logic [3:0]    copy_cnt;
  logic [3:0]    fill_inc;

  logic [AW:0]   wp_ext;
  logic [AW:0]   dist_ext;
  logic [AW:0]   rd_full;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wp_inc;
  logic [7:0]    emit_byte;
  logic          emit_last;
  logic          rec_close;

  assign copy_dist = {high_r[5:0], c_r[7:3]};
  assign len       = {1'b0, c_r[2:0]} + LEN_BASE;
  assign oc17      = {1'b0, out_count_r};
  assign lim17     = {1'b0, out_limit_r};
  assign room17    = lim17 - oc17;
  assign fill_inc  = filled_r + 4'd1;

  always_comb begin
    if (oc17 >= lim17) begin
      copy_cnt = 4'd0;
    end else if (room17 >= {13'd0, len}) begin
      copy_cnt = len;
    end else begin
      copy_cnt = room17[3:0];
    end
  end

  always_comb begin
    pend_nxt   = pend_r;
    high_nxt   = high_r;
    exp_nxt    = exp_r;
    filled_nxt = filled_r;
    halt_nxt   = halt_r;
    kind_nxt   = KIND_LIT;
    cnt_nxt    = 4'd0;
    run_wr     = 1'b0;
    priority if (halt_r != ST_OK) begin
      kind_nxt = KIND_LIT;  // halted: input is dropped
    end else if (pend_r) begin
      pend_nxt = 1'b0;
      if (copy_dist == 11'd0 || {5'd0, copy_dist} > out_count_r) begin
        halt_nxt = ST_BAD_DIST;
      end else begin
        kind_nxt = KIND_COPY;
        cnt_nxt  = copy_cnt;
        if (copy_cnt != len) begin
          halt_nxt = ST_LIMIT;
        end
      end
    end else if (exp_r != 4'd0) begin
      run_wr     = 1'b1;
      filled_nxt = fill_inc;
      if (fill_inc >= exp_r) begin
        if (oc17 + {13'd0, exp_r} > lim17) begin
          halt_nxt = ST_LIMIT;
        end else begin
          kind_nxt = KIND_RUN;
          cnt_nxt  = exp_r;
        end
        exp_nxt    = 4'd0;
        filled_nxt = 4'd0;
      end
    end else if (oc17 >= lim17) begin
      halt_nxt = ST_LIMIT;
    end else if (c_r != 8'h00 && c_r <= RUN_MAX) begin
      if (last_r) begin
        halt_nxt = ST_CUT;
      end else begin
        exp_nxt    = c_r[3:0];
        filled_nxt = 4'd0;
      end
    end else if (c_r <= LIT_MAX) begin
      kind_nxt = KIND_LIT;
      cnt_nxt  = 4'd1;
    end else if (c_r <= PAIR_MAX) begin
      if (last_r) begin
        halt_nxt = ST_CUT;
      end else begin
        pend_nxt = 1'b1;
        high_nxt = c_r;
      end
    end else if (oc17 + 17'd2 > lim17) begin
      halt_nxt = ST_LIMIT;
    end else begin
      kind_nxt = KIND_SPACE;
      cnt_nxt  = 4'd2;
    end
    // a pair or run still open at the record end is a cut-off code
    if (last_r && halt_nxt == ST_OK && (pend_nxt || exp_nxt != 4'd0)) begin
      halt_nxt = ST_CUT;
    end
  end

  // history read address wraps modulo the depth
  assign wp_ext   = {1'b0, wp_r};
  assign dist_ext = {{(AW-10){1'b0}}, dist_r};
  assign rd_full  = (wp_ext >= dist_ext) ? (wp_ext - dist_ext)
                                         : (wp_ext + DEPTH_C - dist_ext);
  assign rd_addr  = rd_full[AW-1:0];
  assign wp_inc   = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;

  always_comb begin
    unique case (kind_r)
      KIND_LIT:   emit_byte = c_r;
      KIND_SPACE: emit_byte = (k_r == 4'd0) ? SPACE_CHAR : (c_r ^ XOR_MASK);
      KIND_RUN:   emit_byte = run_buf[k_r[2:0]];
      KIND_COPY:  emit_byte = rdata_r;
      default:    emit_byte = c_r;
    endcase
  end

  assign emit_last = (k_r == cnt_r - 4'd1);
  assign rec_close = (cmd.emit && emit_last && last_r) || cmd.mark;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hist_mem[wp_r] <= emit_byte;
    end
    if (cmd.fetch) begin
      rdata_r <= hist_mem[rd_addr];
    end
    if (cmd.decode && run_wr) begin
      run_buf[filled_r[2:0]] <= c_r;
    end
    if (cmd.load) begin
      c_r <= in_byte;
    end
    if (cmd.decode) begin
      dist_r <= copy_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_limit_r <= LIMIT_RESET;
      out_count_r <= '0;
      wp_r        <= '0;
      pend_r      <= 1'b0;
      high_r      <= '0;
      exp_r       <= '0;
      filled_r    <= '0;
      halt_r      <= ST_OK;
      kind_r      <= KIND_LIT;
      cnt_r       <= '0;
      k_r         <= '0;
      last_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        out_limit_r <= cfg_wdata;
      end
      if (cmd.load) begin
        last_r <= in_record_end;
      end
      if (cmd.decode) begin
        pend_r   <= pend_nxt;
        high_r   <= high_nxt;
        exp_r    <= exp_nxt;
        filled_r <= filled_nxt;
        halt_r   <= halt_nxt;
        kind_r   <= kind_nxt;
        cnt_r    <= cnt_nxt;
        k_r      <= '0;
      end
      if (cmd.emit) begin
        out_count_r <= out_count_r + 16'd1;
        wp_r        <= wp_inc;
        k_r         <= k_r + 4'd1;
      end
      if (rec_close) begin
        out_count_r <= '0;
        wp_r        <= '0;
        pend_r      <= 1'b0;
        high_r      <= '0;
        exp_r       <= '0;
        filled_r    <= '0;
        halt_r      <= ST_OK;
      end
    end
  end

  // output register, loaded only when empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.mark) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.mark) begin
      out_byte_r <= cmd.mark ? 8'h00 : emit_byte;
      out_bv_r   <= cmd.emit;
      out_rl_r   <= cmd.mark || emit_last;
      out_rd_r   <= rec_close;
      out_st_r   <= rec_close ? halt_r : ST_OK;
      if (!rec_close) begin
        out_len_r <= '0;
      end else if (cmd.mark) begin
        out_len_r <= out_count_r;
      end else begin
        out_len_r <= out_count_r + 16'd1;
      end
    end
  end

  assign stat.dec_zero  = (cnt_nxt == 4'd0);
  assign stat.dec_copy  = (kind_nxt == KIND_COPY);
  assign stat.job_copy  = (kind_r == KIND_COPY);
  assign stat.emit_last = emit_last;
  assign stat.rec_last  = last_r;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_byte_valid     = out_bv_r;
  assign out_run_last       = out_rl_r;
  assign out_record_done    = out_rd_r;
  assign out_status         = out_st_r;
  assign out_decoded_length = out_len_r;

endmodule

[rtl/palmdoc_lz77_decompressor_top.sv]
// flow: an accepted byte is decoded, then each of its results is emitted into the output register
// a byte that yields no data goes back to idle, or emits an end marker at a record end;
//   an emit (literal, space pair, run byte or end marker) waits while the output is stalled
// copies read the history port in a fetch state before each byte (at most 10 bytes per copy);
// input is taken only between items
// reset: synchronous active-low rst_n clears record state, limit returns to 16416
// ----------------------------------------------------------------------------
// palmdoc_lz77_decompressor_top
// palmdoc lz77 record decompressor, one compressed byte per transaction
// ----------------------------------------------------------------------------
module palmdoc_lz77_decompressor_top import pdlz_pkg::*; #(
  parameter int HISTORY_DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_record_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_run_last,
  output logic        out_record_done,
  output logic [1:0]  out_status,
  output logic [15:0] out_decoded_length
);

  pdlz_cmd_t  cmd;
  pdlz_stat_t stat;

  pdlz_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pdlz_dpath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_byte            (in_byte),
    .in_record_end      (in_record_end),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_run_last       (out_run_last),
    .out_record_done    (out_record_done),
    .out_status         (out_status),
    .out_decoded_length (out_decoded_length)
  );

endmodule

[rtl/pdlz_checker.sv]
// ----------------------------------------------------------------------------
// pdlz_checker
// port-level checks on the decompressor result channel
// ----------------------------------------------------------------------------
`include "palmdoc_lz77_decompressor_top_defines.svh"

module pdlz_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_byte_valid,
  input logic        out_run_last,
  input logic        out_record_done,
  input logic [1:0]  out_status,
  input logic [15:0] out_decoded_length
);

  // closing a record always ends the transaction group of its item
  `PDLZ_ASSERT_IMP(a_done_is_last, out_valid && out_record_done, out_run_last)

  // an end marker without data only ever closes a record
  `PDLZ_ASSERT_IMP(a_marker_closes, out_valid && !out_byte_valid, out_record_done)

  // status and length stay zero on ordinary data transactions
  `PDLZ_ASSERT_IMP(a_quiet_fields, out_valid && !out_record_done,
                   out_status == 2'd0 && out_decoded_length == 16'd0)

  // a stalled result holds
  `PDLZ_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_byte) && $stable(out_record_done))

endmodule

bind palmdoc_lz77_decompressor_top pdlz_checker u_pdlz_checker (.*);

[verif/pdlz_result_checker.sv]
// ----------------------------------------------------------------------------
// pdlz_result_checker
// watches the byte and result channels of the palmdoc lz77 decompressor,
// decodes every accepted byte itself and compares each result field by field
// ----------------------------------------------------------------------------
module pdlz_result_checker import pdlz_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_record_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_byte_valid,
  input  logic        out_run_last,
  input  logic        out_record_done,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_decoded_length,
  output int          fail_count,
  output int          pending_count,
  output int          results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH = 2048;

  typedef struct packed {
    logic [7:0]  data;
    logic        data_valid;
    logic        item_last;
    logic        closes;
    logic [1:0]  status;
    logic [15:0] length;
  } decoded_t;

  logic [7:0]  hist [HIST_DEPTH];
  logic [7:0]  run_buf [8];
  int          produced;
  logic        pair_pend;
  logic [7:0]  pair_hi;
  logic [3:0]  run_need;
  logic [3:0]  run_have;
  logic [1:0]  halt;
  logic [15:0] limit;
  decoded_t    pending_results[$];
  decoded_t    want;
  int          errors = 0;
  int          seen = 0;

  task automatic clear_record();
    produced  = 0;
    pair_pend = 1'b0;
    pair_hi   = '0;
    run_need  = '0;
    run_have  = '0;
    halt      = ST_OK;
  endtask

  // writes one decoded byte into the history window
  function automatic decoded_t store_byte(input logic [7:0] b);
    decoded_t r;
    hist[produced % HIST_DEPTH] = b;
    produced = (produced + 1) & 16'hFFFF;
    r = '0;
    r.data = b;
    r.data_valid = 1'b1;
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] c, input logic last);
    decoded_t    batch[$];
    decoded_t    r;
    logic [15:0] pair;
    int          copy_dist;
    int          len;
    int          k;
    if (halt != ST_OK) begin
      // halted record, byte dropped
    end else if (pair_pend) begin
      pair_pend = 1'b0;
      pair = {pair_hi, c};
      copy_dist = pair[13:3];
      len  = pair[2:0] + LEN_BASE;
      if (copy_dist == 0 || copy_dist > produced) begin
        halt = ST_BAD_DIST;
      end else begin
        k = 0;
        while (k < len && produced < limit) begin
          batch = {batch, store_byte(hist[(produced - copy_dist) % HIST_DEPTH])};
          k++;
        end
        if (k < len) halt = ST_LIMIT;
      end
    end else if (run_need != 0) begin
      run_buf[run_have[2:0]] = c;
      run_have++;
      if (run_have >= run_need) begin
        // raw run goes out whole or not at all
        if (produced + run_need > limit) begin
          halt = ST_LIMIT;
        end else begin
          for (k = 0; k < run_need; k++) batch = {batch, store_byte(run_buf[k])};
        end
        run_need = '0;
        run_have = '0;
      end
    end else if (produced >= limit) begin
      halt = ST_LIMIT;
    end else if (c != 8'h00 && c <= RUN_MAX) begin
      if (last) begin
        halt = ST_CUT;
      end else begin
        run_need = c[3:0];
        run_have = '0;
      end
    end else if (c <= LIT_MAX) begin
      batch = {batch, store_byte(c)};
    end else if (c <= PAIR_MAX) begin
      if (last) begin
        halt = ST_CUT;
      end else begin
        pair_pend = 1'b1;
        pair_hi   = c;
      end
    end else begin
      if (produced + 2 > limit) begin
        halt = ST_LIMIT;
      end else begin
        batch = {batch, store_byte(SPACE_CHAR)};
        batch = {batch, store_byte(c ^ XOR_MASK)};
      end
    end

    if (last) begin
      if (halt == ST_OK && (pair_pend || run_need != 0)) halt = ST_CUT;
      if (batch.size() == 0) begin
        r = '0;
        batch = {batch, r};
      end
      batch[batch.size() - 1].closes = 1'b1;
      batch[batch.size() - 1].status = halt;
      batch[batch.size() - 1].length = produced[15:0];
      clear_record();
    end
    if (batch.size() > 0) batch[batch.size() - 1].item_last = 1'b1;
    pending_results = {pending_results, batch};
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_record();
      limit = LIMIT_RESET;
      pending_results.delete();
    end else begin
      if (cfg_we) limit = cfg_wdata;
      if (in_valid && in_ready) decode_byte(in_byte, in_record_end);
      if (out_valid && out_ready) begin
        seen++;
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected, out_byte 0x%0h", out_byte);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_byte", 16'(want.data), 16'(out_byte));
          check_field("out_byte_valid", 16'(want.data_valid), 16'(out_byte_valid));
          check_field("out_run_last", 16'(want.item_last), 16'(out_run_last));
          check_field("out_record_done", 16'(want.closes), 16'(out_record_done));
          check_field("out_status", 16'(want.status), 16'(out_status));
          check_field("out_decoded_length", want.length, out_decoded_length);
        end
      end
    end
    fail_count      <= errors;
    pending_count   <= pending_results.size();
    results_checked <= seen;
  end

endmodule

[verif/palmdoc_lz77_decompressor_top_tb.sv]
// ----------------------------------------------------------------------------
// palmdoc_lz77_decompressor_top_tb
// drives compressed records through the decompressor under several output
// limits, with random stalls on both channels; the checker scores the results
// ----------------------------------------------------------------------------
module palmdoc_lz77_decompressor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pdlz_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        in_record_end;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_run_last;
  logic        out_record_done;
  logic [1:0]  out_status;
  logic [15:0] out_decoded_length;

  int fail_count;
  int pending_count;
  int results_checked;

  logic [7:0] record_bytes[$];
  int         planned_len;
  int         bytes_sent = 0;
  int         records_sent = 0;
  int         settings_used = 0;
  bit         no_idle = 1'b0;
  bit         sink_hold_req = 1'b0;
  int         sink_hold_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  palmdoc_lz77_decompressor_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .in_record_end      (in_record_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_run_last       (out_run_last),
    .out_record_done    (out_record_done),
    .out_status         (out_status),
    .out_decoded_length (out_decoded_length)
  );

  pdlz_result_checker u_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .in_record_end      (in_record_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_run_last       (out_run_last),
    .out_record_done    (out_record_done),
    .out_status         (out_status),
    .out_decoded_length (out_decoded_length),
    .fail_count         (fail_count),
    .pending_count      (pending_count),
    .results_checked    (results_checked)
  );

  // one transaction on the byte channel, with an optional gap in front
  task automatic push_byte(input logic [7:0] value, input logic last);
    int gap;
    gap = (!no_idle && $urandom_range(0, 99) < 31) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= value;
    in_record_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (last) records_sent++;
  endtask

  // limit changes only once every result is out and the block has settled
  task automatic write_limit(input logic [15:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic add_token();
    int pick;
    int n;
    int copy_dist;
    int len;
    logic [15:0] pair;
    pick = $urandom_range(0, 99);
    if (pick >= 70 && planned_len == 0) pick = 0;
    if (pick < 35) begin
      n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(9, LIT_MAX);
      record_bytes = {record_bytes, 8'(n)};
      planned_len += 1;
    end else if (pick < 50) begin
      record_bytes = {record_bytes, 8'($urandom_range(PAIR_MAX + 1, 8'hFF))};
      planned_len += 2;
    end else if (pick < 70) begin
      n = $urandom_range(1, RUN_MAX);
      record_bytes = {record_bytes, 8'(n)};
      repeat (n) record_bytes = {record_bytes, 8'($urandom_range(0, 255))};
      planned_len += n;
    end else begin
      copy_dist = $urandom_range(1, (planned_len > 2047) ? 2047 : planned_len);
      len  = $urandom_range(3, 10);
      pair = {2'b10, 11'(copy_dist), 3'(len - 3)};
      record_bytes = {record_bytes, pair[15:8]};
      record_bytes = {record_bytes, pair[7:0]};
      planned_len += len;
    end
  endtask

  // mostly well-formed records, some broken at the tail, a few pure noise
  task automatic send_random_record();
    int pick;
    int n;
    int copy_dist;
    logic [15:0] pair;
    record_bytes.delete();
    planned_len = 0;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      n = $urandom_range(1, 12);
      repeat (n) record_bytes = {record_bytes, 8'($urandom_range(0, 255))};
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) add_token();
      if (pick >= 80) begin
        case ($urandom_range(0, 2))
          0: begin
            record_bytes = {record_bytes,
                            8'($urandom_range(0, 1) ? $urandom_range(1, RUN_MAX) :
                                                      $urandom_range(8'h80, PAIR_MAX))};
          end
          1: begin
            n = $urandom_range(2, RUN_MAX);
            record_bytes = {record_bytes, 8'(n)};
            repeat ($urandom_range(1, n - 1))
              record_bytes = {record_bytes, 8'($urandom_range(0, 255))};
          end
          default: begin
            copy_dist = $urandom_range(0, 1) ? 0 : $urandom_range(planned_len + 1, 2047);
            pair = {2'b10, 11'(copy_dist), 3'($urandom_range(0, 7))};
            record_bytes = {record_bytes, pair[15:8]};
            record_bytes = {record_bytes, pair[7:0]};
            repeat ($urandom_range(0, 3)) add_token();
          end
        endcase
      end
    end
    foreach (record_bytes[i]) push_byte(record_bytes[i], i == record_bytes.size() - 1);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_left > 0) begin
        out_ready <= 1'b0;
        sink_hold_left--;
      end else if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        sink_hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [15:0] phase_limit [6];
    int          target;
    int          waited;
    phase_limit[0] = 16'hFFFF;
    phase_limit[1] = 16'($urandom_range(1, 12));
    phase_limit[2] = 16'($urandom_range(13, 60));
    phase_limit[3] = LIMIT_RESET;
    phase_limit[4] = 16'($urandom_range(61, 400));
    phase_limit[5] = 16'hFFFF;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_byte       <= '0;
    in_record_end <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // literals, spaces, a run and a copy, then a distance past the output
    push_byte(8'h00, 1'b0);
    push_byte(LIT_MAX, 1'b0);
    push_byte(8'h09, 1'b0);
    push_byte(8'hC0, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(PAIR_MAX, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h41, 1'b1);
    // codes cut off by the record end
    push_byte(8'h05, 1'b1);
    push_byte(8'h90, 1'b1);
    push_byte(8'h03, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b1);
    // zero distance
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b1);

    write_limit(16'd0);
    push_byte(8'h41, 1'b1);
    write_limit(16'd1);
    push_byte(8'hC1, 1'b1);
    push_byte(8'h41, 1'b1);
    push_byte(8'h41, 1'b0);
    push_byte(8'h42, 1'b1);
    // copy clipped by the limit
    write_limit(16'd4);
    push_byte(8'h41, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h0F, 1'b1);

    for (int p = 0; p < 6; p++) begin
      write_limit(phase_limit[p]);
      no_idle = (p == 1);
      if (p == 3) sink_hold_req = 1'b1;
      target = bytes_sent + 70;
      while (bytes_sent < target) send_random_record();
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    waited = 0;
    while (pending_count != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);

    $display("run covered %0d compressed bytes in %0d records, %0d results checked",
             bytes_sent, records_sent, results_checked);
    $display("output limit written %0d times, extremes 0, 1 and 65535 included",
             settings_used);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
